// File: hdl/rhht_pkg.sv
`timescale 1ns / 1ps

package rhht_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 256;
	localparam int unsigned KEY_BITS        = 32;
	localparam int unsigned VALUE_BITS      = 32;
	localparam int unsigned HASH_BITS       = 32;
	localparam int unsigned CFG_BITS        = 9;
	localparam int unsigned CFG_IDX_BITS    = 1;
	localparam int unsigned COUNT_BITS      = 9;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX    = 9'd511;
	localparam logic [CFG_BITS-1:0]   CFG_SIZE_RST = 9'd256;
	localparam logic [CFG_BITS-1:0]   CFG_FILL_RST = 9'd192;

	localparam logic [CFG_IDX_BITS-1:0] REG_TABLE_SIZE = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FILL_LIMIT = 1'b1;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_REMOVED   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [KEY_BITS-1:0]   key;
		logic [HASH_BITS-1:0]  key_hash;
		logic [VALUE_BITS-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [VALUE_BITS-1:0] data_out;
		logic [COUNT_BITS-1:0] count_out;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CAP,
		S_CAP2,
		S_SQ,
		S_MODGO,
		S_MODW,
		S_RD,
		S_CHK,
		S_UNDO,
		S_UNDO_W,
		S_DONE
	} state_t;

endpackage

// File: hdl/robin_hood_hash_table.sv
`timescale 1ns / 1ps

// Robin Hood hash table, quadratic probing, one operation at a time. Raise start
// while busy is low to hand in a beat; busy stays high until the single result
// beat, shown for exactly one cycle with done high; the receiver cannot stall it.
// After reset the block sweeps its whole slot memory (busy high) before the first
// beat is taken; configuration writes are taken at any time but must only be
// issued while idle. Timing is set by one serial remainder unit and one slot
// memory port: a lookup or remove runs the remainder once, then reads and checks
// each slot probed; an insert first computes its probe cap, reruns the remainder
// for each displacement, and visits each displaced slot again when its journal
// is replayed at the end.
module robin_hood_hash_table #(
	parameter int unsigned TABLE_DEPTH = rhht_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  rhht_pkg::req_t                        req,
	output logic                                  done,
	output rhht_pkg::rsp_t                        rsp,
	input  logic                                  cfg_we,
	input  logic [rhht_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [rhht_pkg::CFG_BITS-1:0]         cfg_data
);

	localparam int unsigned IDX_BITS  = $clog2(TABLE_DEPTH);
	localparam int unsigned SIZE_BITS = IDX_BITS + 1;
	localparam int unsigned MARK_BITS = SIZE_BITS + 1;
	localparam int unsigned PROD_BITS = 2 * SIZE_BITS;
	localparam int unsigned STEP_BITS = PROD_BITS + 1;
	localparam int unsigned DIV_BITS  =
		((PROD_BITS > rhht_pkg::HASH_BITS) ? PROD_BITS : rhht_pkg::HASH_BITS) + 1;
	localparam int unsigned SUM_BITS  = SIZE_BITS + 2;
	localparam logic [MARK_BITS-1:0] MARK_TOMB = {MARK_BITS{1'b1}};

	// one slot: stored key, value, hash and probe mark (0 empty, all ones tombstone)
	typedef struct packed {
		logic [rhht_pkg::KEY_BITS-1:0]   key;
		logic [rhht_pkg::VALUE_BITS-1:0] val;
		logic [rhht_pkg::HASH_BITS-1:0]  hash;
		logic [MARK_BITS-1:0]            mark;
	} slot_t;

	// undo journal entry: first prior content of a slot overwritten by a swap
	typedef struct packed {
		logic [IDX_BITS-1:0] idx;
		slot_t               slot;
	} jnl_t;

	rhht_pkg::state_t state_q, state_d;

	// configuration
	logic [rhht_pkg::CFG_BITS-1:0]   tbl_size_q;
	logic [rhht_pkg::CFG_BITS-1:0]   fill_q;
	logic [rhht_pkg::COUNT_BITS-1:0] count_q;

	// operation context
	logic [1:0]                        op_q;
	logic [rhht_pkg::KEY_BITS-1:0]     key_q;
	logic [rhht_pkg::HASH_BITS-1:0]    hash_q;
	logic [rhht_pkg::VALUE_BITS-1:0]   val_q;
	logic [SIZE_BITS-1:0]              p_q;
	logic [IDX_BITS-1:0]               idx_q;
	logic [IDX_BITS-1:0]               nidx_q;
	logic [STEP_BITS-1:0]              steps_q;
	logic [STEP_BITS-1:0]              cap_q;
	logic [PROD_BITS-1:0]              mul_q;
	logic                              tomb_seen_q;
	logic [IDX_BITS-1:0]               tomb_idx_q;
	logic [SIZE_BITS-1:0]              tomb_p_q;
	logic [SIZE_BITS-1:0]              jcnt_q;
	logic                              restore_q;
	logic [SIZE_BITS-1:0]              clr_q;
	logic [2:0]                        status_q;
	logic [rhht_pkg::VALUE_BITS-1:0]   data_q;

	// memories
	slot_t ent_mem [TABLE_DEPTH];
	logic  tch_mem [TABLE_DEPTH];
	jnl_t  jnl_mem [TABLE_DEPTH];
	slot_t ent_rd_q;
	logic  tch_rd_q;
	jnl_t  jnl_rd_q;

	logic                ent_we;
	logic [IDX_BITS-1:0] ent_wa;
	slot_t               ent_wd;
	logic                tch_we;
	logic [IDX_BITS-1:0] tch_wa;
	logic                tch_wd;
	logic                jnl_we;
	jnl_t                jnl_wd;
	logic [IDX_BITS-1:0] jnl_ra;

	// shared remainder unit
	logic                 mod_go;
	logic                 mod_done;
	logic [IDX_BITS-1:0]  mod_rem;
	logic [DIV_BITS-1:0]  mod_dividend;

	// combinational helpers
	logic [SIZE_BITS-1:0] size;
	logic [SIZE_BITS-1:0] mul_op;
	logic [SIZE_BITS-1:0] p1;
	logic [SUM_BITS-1:0]  sum_a, sum_b, sum_c, size_ext;
	logic                 ins_refuse;
	logic                 probe_over;
	logic                 is_ins;
	logic                 is_empty, is_tomb, is_match, is_swap;

	// effective size: zero acts as one, clamp at the physical depth
	always_comb begin
		if (tbl_size_q == '0)
			size = SIZE_BITS'(1);
		else if (32'(tbl_size_q) > TABLE_DEPTH)
			size = SIZE_BITS'(TABLE_DEPTH);
		else
			size = SIZE_BITS'(tbl_size_q);
	end

	assign is_ins     = (op_q == rhht_pkg::OP_INSERT);
	assign ins_refuse = (count_q > fill_q) || (count_q == rhht_pkg::COUNT_MAX);
	assign probe_over = (p_q >= size) || (is_ins && (steps_q >= cap_q));
	assign p1         = p_q + 1'b1;

	// classification of the slot just read
	assign is_empty = (ent_rd_q.mark == '0);
	assign is_tomb  = (ent_rd_q.mark == MARK_TOMB);
	assign is_match = (ent_rd_q.hash == hash_q) && (ent_rd_q.key == key_q);
	assign is_swap  = (ent_rd_q.mark < {1'b0, p1});

	// next probe slot: (h + (p+1)^2) = (h + p^2) + 2p + 1, result below 3*size
	assign size_ext = SUM_BITS'(size);
	assign sum_a    = SUM_BITS'(idx_q) + (SUM_BITS'(p_q) << 1) + SUM_BITS'(1);
	assign sum_b    = (sum_a >= size_ext) ? (sum_a - size_ext) : sum_a;
	assign sum_c    = (sum_b >= size_ext) ? (sum_b - size_ext) : sum_b;

	assign mul_op       = (state_q == rhht_pkg::S_CAP) ? size : p_q;
	assign mod_dividend = DIV_BITS'(hash_q) + DIV_BITS'(mul_q);
	assign jnl_ra       = IDX_BITS'(jcnt_q - 1'b1);

	rhht_mod #(
		.DIVIDEND_BITS (DIV_BITS),
		.REM_BITS      (IDX_BITS)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (mod_go),
		.dividend (mod_dividend),
		.divisor  (size),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rhht_pkg::S_CLEAR: begin
				if (clr_q == SIZE_BITS'(TABLE_DEPTH - 1))
					state_d = rhht_pkg::S_IDLE;
			end
			rhht_pkg::S_IDLE: begin
				if (start) begin
					case (req.opcode)
						rhht_pkg::OP_INSERT:
							state_d = ins_refuse ? rhht_pkg::S_DONE : rhht_pkg::S_CAP;
						rhht_pkg::OP_LOOKUP, rhht_pkg::OP_REMOVE:
							state_d = rhht_pkg::S_SQ;
						default:
							state_d = rhht_pkg::S_DONE;
					endcase
				end
			end
			rhht_pkg::S_CAP:   state_d = rhht_pkg::S_CAP2;
			rhht_pkg::S_CAP2:  state_d = rhht_pkg::S_SQ;
			rhht_pkg::S_SQ:    state_d = rhht_pkg::S_MODGO;
			rhht_pkg::S_MODGO: state_d = rhht_pkg::S_MODW;
			rhht_pkg::S_MODW: begin
				if (mod_done)
					state_d = rhht_pkg::S_RD;
			end
			rhht_pkg::S_RD: begin
				if (!probe_over)
					state_d = rhht_pkg::S_CHK;
				else if (is_ins)
					state_d = rhht_pkg::S_UNDO;
				else
					state_d = rhht_pkg::S_DONE;
			end
			rhht_pkg::S_CHK: begin
				if (is_ins) begin
					if (is_empty || (!is_tomb && is_match))
						state_d = rhht_pkg::S_UNDO;
					else if (!is_tomb && is_swap)
						state_d = rhht_pkg::S_SQ;
					else
						state_d = rhht_pkg::S_RD;
				end else begin
					if (is_empty || (!is_tomb && is_match))
						state_d = rhht_pkg::S_DONE;
					else
						state_d = rhht_pkg::S_RD;
				end
			end
			rhht_pkg::S_UNDO: begin
				if (jcnt_q == '0)
					state_d = rhht_pkg::S_DONE;
				else
					state_d = rhht_pkg::S_UNDO_W;
			end
			rhht_pkg::S_UNDO_W: state_d = rhht_pkg::S_UNDO;
			rhht_pkg::S_DONE:   state_d = rhht_pkg::S_IDLE;
			default:            state_d = rhht_pkg::S_IDLE;
		endcase
	end

	// memory strobes and write data
	always_comb begin
		ent_we = 1'b0;
		ent_wa = idx_q;
		ent_wd = ent_rd_q;
		tch_we = 1'b0;
		tch_wa = idx_q;
		tch_wd = 1'b0;
		jnl_we = 1'b0;
		jnl_wd = '{idx: idx_q, slot: ent_rd_q};
		mod_go = 1'b0;
		unique case (state_q)
			rhht_pkg::S_CLEAR: begin
				ent_we = 1'b1;
				ent_wa = clr_q[IDX_BITS-1:0];
				ent_wd = '0;
				tch_we = 1'b1;
				tch_wa = clr_q[IDX_BITS-1:0];
			end
			rhht_pkg::S_MODGO: mod_go = 1'b1;
			rhht_pkg::S_CHK: begin
				if (is_ins) begin
					if (is_empty) begin
						// land in the first passed tombstone if one is held
						ent_we = 1'b1;
						ent_wa = tomb_seen_q ? tomb_idx_q : idx_q;
						ent_wd = '{key: key_q, val: val_q, hash: hash_q,
							mark: tomb_seen_q ? {1'b0, tomb_p_q} : {1'b0, p1}};
					end else if (!is_tomb && !is_match && is_swap) begin
						ent_we = 1'b1;
						ent_wd = '{key: key_q, val: val_q, hash: hash_q, mark: {1'b0, p1}};
						// journal only the first overwrite of a slot
						if (!tch_rd_q) begin
							jnl_we = 1'b1;
							tch_we = 1'b1;
							tch_wd = 1'b1;
						end
					end
				end else if (op_q == rhht_pkg::OP_REMOVE && !is_empty && !is_tomb
						&& is_match) begin
					ent_we      = 1'b1;
					ent_wd.mark = MARK_TOMB;
				end
			end
			rhht_pkg::S_UNDO_W: begin
				tch_we = 1'b1;
				tch_wa = jnl_rd_q.idx;
				if (restore_q) begin
					ent_we = 1'b1;
					ent_wa = jnl_rd_q.idx;
					ent_wd = jnl_rd_q.slot;
				end
			end
			default: ;
		endcase
	end

	// slot, touched-flag and journal memories
	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[ent_wa] <= ent_wd;
		ent_rd_q <= ent_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (tch_we)
			tch_mem[tch_wa] <= tch_wd;
		tch_rd_q <= tch_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (jnl_we)
			jnl_mem[jcnt_q[IDX_BITS-1:0]] <= jnl_wd;
		jnl_rd_q <= jnl_mem[jnl_ra];
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rhht_pkg::S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			tbl_size_q  <= rhht_pkg::CFG_SIZE_RST;
			fill_q      <= rhht_pkg::CFG_FILL_RST;
			tomb_seen_q <= 1'b0;
			jcnt_q      <= '0;
			restore_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			mul_q   <= PROD_BITS'(mul_op) * PROD_BITS'(mul_op);

			if (cfg_we) begin
				unique case (cfg_index)
					rhht_pkg::REG_TABLE_SIZE: tbl_size_q <= cfg_data;
					rhht_pkg::REG_FILL_LIMIT: fill_q     <= cfg_data;
				endcase
			end

			unique case (state_q)
				rhht_pkg::S_CLEAR: clr_q <= clr_q + 1'b1;
				rhht_pkg::S_IDLE: begin
					if (start) begin
						op_q        <= req.opcode;
						key_q       <= req.key;
						hash_q      <= req.key_hash;
						val_q       <= req.data_in;
						p_q         <= '0;
						steps_q     <= '0;
						data_q      <= '0;
						tomb_seen_q <= 1'b0;
						jcnt_q      <= '0;
						restore_q   <= 1'b0;
						if (req.opcode == rhht_pkg::OP_INSERT && ins_refuse)
							status_q <= rhht_pkg::ST_FULL;
						else
							status_q <= rhht_pkg::ST_NOT_FOUND;
					end
				end
				rhht_pkg::S_CAP2: cap_q <= STEP_BITS'(mul_q) + STEP_BITS'(size);
				rhht_pkg::S_MODW: begin
					if (mod_done)
						idx_q <= mod_rem;
				end
				rhht_pkg::S_RD: begin
					nidx_q <= IDX_BITS'(sum_c);
					if (probe_over && is_ins) begin
						status_q  <= rhht_pkg::ST_FULL;
						restore_q <= 1'b1;
					end
				end
				rhht_pkg::S_CHK: begin
					if (is_ins) begin
						steps_q <= steps_q + 1'b1;
						if (is_empty) begin
							status_q <= rhht_pkg::ST_INSERTED;
							count_q  <= count_q + 1'b1;
						end else if (is_tomb) begin
							if (!tomb_seen_q) begin
								tomb_seen_q <= 1'b1;
								tomb_idx_q  <= idx_q;
								tomb_p_q    <= p1;
							end
							p_q   <= p1;
							idx_q <= nidx_q;
						end else if (is_match) begin
							status_q  <= rhht_pkg::ST_DUPLICATE;
							restore_q <= 1'b1;
						end else if (is_swap) begin
							// carry the displaced resident on from its own probe count
							key_q       <= ent_rd_q.key;
							val_q       <= ent_rd_q.val;
							hash_q      <= ent_rd_q.hash;
							p_q         <= ent_rd_q.mark[SIZE_BITS-1:0];
							tomb_seen_q <= 1'b0;
							if (!tch_rd_q)
								jcnt_q <= jcnt_q + 1'b1;
						end else begin
							p_q   <= p1;
							idx_q <= nidx_q;
						end
					end else begin
						if (!is_empty && !is_tomb && is_match) begin
							data_q <= ent_rd_q.val;
							if (op_q == rhht_pkg::OP_REMOVE) begin
								status_q <= rhht_pkg::ST_REMOVED;
								if (count_q != '0)
									count_q <= count_q - 1'b1;
							end else begin
								status_q <= rhht_pkg::ST_FOUND;
							end
						end else if (!is_empty) begin
							p_q   <= p1;
							idx_q <= nidx_q;
						end
					end
				end
				rhht_pkg::S_UNDO_W: jcnt_q <= jcnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	// result beat
	assign busy = (state_q != rhht_pkg::S_IDLE);
	assign done = (state_q == rhht_pkg::S_DONE);
	assign rsp  = '{status: status_q, data_out: data_q, count_out: count_q};

endmodule

// File: hdl/rhht_mod.sv
`timescale 1ns / 1ps

// bit-serial remainder, one dividend bit per cycle
module rhht_mod #(
	parameter int unsigned DIVIDEND_BITS = 33,
	parameter int unsigned REM_BITS      = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [REM_BITS:0]        divisor,
	output logic                     done,
	output logic [REM_BITS-1:0]      rem
);

	localparam int unsigned CNT_BITS = $clog2(DIVIDEND_BITS + 1);

	logic [CNT_BITS-1:0]      cnt_q;
	logic [DIVIDEND_BITS-1:0] sh_q;
	logic [REM_BITS-1:0]      rem_q;
	logic [REM_BITS:0]        div_q;
	logic                     done_q;
	logic [REM_BITS:0]        trial;

	assign trial = {rem_q, sh_q[DIVIDEND_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNT_BITS'(DIVIDEND_BITS);
				sh_q  <= dividend;
				rem_q <= '0;
				div_q <= divisor;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				sh_q  <= sh_q << 1;
				if (trial >= div_q)
					rem_q <= REM_BITS'(trial - div_q);
				else
					rem_q <= REM_BITS'(trial);
				done_q <= (cnt_q == CNT_BITS'(1));
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: hdl/rhht_checker.sv
`timescale 1ns / 1ps

module rhht_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input rhht_pkg::rsp_t rsp
);

	// an accepted beat keeps the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// result only while an operation is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result beat while idle");

	// one result beat per operation
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat longer than one cycle");

	// data only on found or removed
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != rhht_pkg::ST_FOUND && rsp.status != rhht_pkg::ST_REMOVED)
		|-> (rsp.data_out == '0))
		else $error("nonzero data on a result without a value");

	// legal status code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status <= rhht_pkg::ST_FULL))
		else $error("undefined status code");

endmodule

bind robin_hood_hash_table rhht_checker u_rhht_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
